/* rtl/assert_macros.svh */
// assertion macros for the checker module
// no dependencies; clk and rst_n must exist in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/skvt_pkg.sv */
// package for the slotted key/value table: widths, codes and the
// controller/datapath interface structs; no dependencies
package skvt_pkg;

    localparam int SLOTS_DEF = 128;
    localparam int OP_W      = 2;
    localparam int KEY_W     = 31;
    localparam int VAL_W     = 31;
    localparam int STATUS_W  = 2;
    localparam int IN_W      = 64;
    localparam int OUT_W     = 40;
    localparam int PAD_W     = OUT_W - STATUS_W - VAL_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic    clear_step;
        logic    capture;
        logic    scan_start;
        logic    scan_step;
        logic    write_ins;
        logic    write_del;
        logic    set_res;
        status_t res_status;
        logic    res_take_value;
        logic    load_out;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic            clear_last;
        logic            rvalid;
        logic            rlast;
        logic            hit;
        logic            free;
        logic [OP_W-1:0] op;
        logic            out_free;
    } dp_stat_t;

endpackage

/* rtl/skvt_datapath.sv */
// datapath: slot memory, scan address counter, compare, result and output registers
// depends on skvt_pkg
module skvt_datapath
    import skvt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_cmd_t         cmd,
    output dp_stat_t         stat,
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(SLOTS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SLOTS - 1);

    entry_t mem [SLOTS];

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              issuing_reg, issuing_next;
    logic              rvalid_reg, rvalid_next;
    logic [ADDR_W-1:0] raddr_reg;
    entry_t            rdata_reg;

    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;

    status_t           res_status_reg;
    logic [VAL_W-1:0]  res_value_reg;
    status_t           out_status_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic              m_tvalid_reg, m_tvalid_next;

    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    assign rd_en = cmd.scan_step && issuing_reg;

    always_comb
    begin
        addr_next    = addr_reg;
        issuing_next = issuing_reg;
        rvalid_next  = 1'b0;
        if (cmd.clear_step)
        begin
            addr_next = addr_reg + 1'b1;
        end
        else if (cmd.scan_start)
        begin
            addr_next    = '0;
            issuing_next = 1'b1;
        end
        else if (rd_en)
        begin
            addr_next   = addr_reg + 1'b1;
            rvalid_next = 1'b1;
            if (addr_reg == LAST_ADDR)
            begin
                issuing_next = 1'b0;
            end
        end
    end

    // one write port shared by the clearing pass, insert and delete
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = raddr_reg;
        wr_data = '0;
        if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_reg;
        end
        else if (cmd.write_ins)
        begin
            wr_en   = 1'b1;
            wr_data = '{used: 1'b1, key: key_reg, value: val_reg};
        end
        else if (cmd.write_del)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr_reg];
            raddr_reg <= addr_reg;
        end
        if (cmd.capture)
        begin
            op_reg  <= s_tdata[OP_W-1:0];
            key_reg <= s_tdata[OP_W +: KEY_W];
            val_reg <= s_tdata[OP_W+KEY_W +: VAL_W];
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_take_value ? rdata_reg.value : '0;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            issuing_reg  <= 1'b0;
            rvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            addr_reg     <= addr_next;
            issuing_reg  <= issuing_next;
            rvalid_reg   <= rvalid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign stat.clear_last = (addr_reg == LAST_ADDR);
    assign stat.rvalid     = rvalid_reg;
    assign stat.rlast      = (raddr_reg == LAST_ADDR);
    assign stat.hit        = rdata_reg.used && (rdata_reg.key == key_reg);
    assign stat.free       = !rdata_reg.used;
    assign stat.op         = op_reg;
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_value_reg, out_status_reg};

endmodule

/* rtl/skvt_ctrl.sv */
// controller state machine: clearing pass, command scan, result hand-off
// depends on skvt_pkg
module skvt_ctrl
    import skvt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   del_hit_reg, del_hit_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        del_hit_next = del_hit_reg;
        cmd          = '0;
        cmd.res_status = ST_MISS;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture    = 1'b1;
                    cmd.scan_start = 1'b1;
                    del_hit_next   = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.rvalid)
                begin
                    case (stat.op)
                        OP_INSERT:
                        begin
                            if (stat.free)
                            begin
                                cmd.write_ins  = 1'b1;
                                cmd.set_res    = 1'b1;
                                cmd.res_status = ST_OK;
                                state_next     = S_DONE;
                            end
                            else if (stat.rlast)
                            begin
                                cmd.set_res    = 1'b1;
                                cmd.res_status = ST_FULL;
                                state_next     = S_DONE;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (stat.hit)
                            begin
                                cmd.set_res        = 1'b1;
                                cmd.res_status     = ST_OK;
                                cmd.res_take_value = 1'b1;
                                state_next         = S_DONE;
                            end
                            else if (stat.rlast)
                            begin
                                cmd.set_res = 1'b1;
                                state_next  = S_DONE;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (stat.hit)
                            begin
                                cmd.write_del = 1'b1;
                                del_hit_next  = 1'b1;
                            end
                            if (stat.rlast)
                            begin
                                cmd.set_res    = 1'b1;
                                cmd.res_status = (del_hit_reg || stat.hit) ? ST_OK : ST_MISS;
                                state_next     = S_DONE;
                            end
                        end
                        default:
                        begin
                            cmd.set_res = 1'b1;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            del_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            del_hit_reg <= del_hit_next;
        end
    end

endmodule

/* rtl/slotted_key_value_table.sv */
// Slotted key/value table with SLOTS slots held in one memory, one entry read per cycle.
// After reset the block clears the used marks in one pass over all slots before it takes
// its first transaction. Each command then scans the slots in address order: insert stops
// at the first free slot and lookup at the first matching slot, so the result is valid the
// sooner the earlier the scan ends, and the next command is taken once the result has moved
// into the output register. Delete, a lookup miss and an insert into a full table walk every
// slot; an unused opcode ends at slot 0. The single memory read port sets the pace of the
// scan. A finished result sits in an output register, so the next command is taken while
// the previous result waits downstream.
// Depends on skvt_pkg, skvt_ctrl and skvt_datapath.
module slotted_key_value_table
    import skvt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // opcode[1:0], key[32:2], value[63:33]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0], found_value[32:2], zero[39:33]
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    skvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    skvt_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/skvt_checker.sv */
// port-level checks for the slotted key/value table, bound to the top level
// depends on skvt_pkg and assert_macros.svh
`include "assert_macros.svh"

module skvt_checker
    import skvt_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] out_status;
    logic [VAL_W-1:0]    out_value;
    logic [PAD_W-1:0]    out_pad;

    assign out_status = m_tdata[STATUS_W-1:0];
    assign out_value  = m_tdata[STATUS_W +: VAL_W];
    assign out_pad    = m_tdata[OUT_W-1 -: PAD_W];

    `ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "command taken while another is in work")
    `ASSERT_IMPL(a_status_code, m_tvalid, out_status == ST_OK || out_status == ST_MISS || out_status == ST_FULL, "bad status code")
    `ASSERT_IMPL(a_value_zero, m_tvalid && out_status != ST_OK, out_value == '0, "value set on miss or full")
    `ASSERT_IMPL(a_pad_zero, m_tvalid, out_pad == '0, "padding bits set")

endmodule

bind slotted_key_value_table skvt_checker u_chk (.*);

/* tb/tb_top.sv */
// testbench for slotted_key_value_table: a stream driver and a result monitor around
// one dut, with an in-bench model of the slot table that predicts each reply
// depends on skvt_pkg and rtl/slotted_key_value_table.sv
module tb_top
    import skvt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = SLOTS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam int RANDOM_ITEMS = 1250;
    localparam int POOL_SIZE = 32;

    typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN, MODE_NOISE} round_mode_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        bit               drain_first;
    } table_cmd_t;

    typedef struct {
        status_t          status;
        logic [VAL_W-1:0] found;
    } table_reply_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;    // opcode, key, value
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // status, found_value, zero pad

    // shadow copy of the slot table
    logic [KEY_W-1:0] shadow_key [SLOTS];
    logic [VAL_W-1:0] shadow_val [SLOTS];
    bit               shadow_used [SLOTS];

    table_cmd_t   cmd_q [$];
    table_reply_t reply_q [$];
    table_cmd_t   cur_cmd;
    table_reply_t want;
    int           fail_count = 0;

    int gap_left = 0;
    int burst_left = 1;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_phase = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    slotted_key_value_table #(.SLOTS(SLOTS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic table_reply_t apply_command(table_cmd_t c);
        table_reply_t r;
        r.status = ST_MISS;
        r.found = '0;
        if (c.op == OP_INSERT)
        begin
            r.status = ST_FULL;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!shadow_used[i])
                begin
                    shadow_key[i] = c.key;
                    shadow_val[i] = c.value;
                    shadow_used[i] = 1'b1;
                    r.status = ST_OK;
                    break;
                end
            end
        end
        else if (c.op == OP_LOOKUP)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (shadow_used[i] && shadow_key[i] == c.key)
                begin
                    r.found = shadow_val[i];
                    r.status = ST_OK;
                    break;
                end
            end
        end
        else if (c.op == OP_DELETE)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (shadow_used[i] && shadow_key[i] == c.key)
                begin
                    shadow_used[i] = 1'b0;
                    r.status = ST_OK;
                end
            end
        end
        return r;
    endfunction

    task automatic add_cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                           logic [VAL_W-1:0] value, bit drain_first);
        table_cmd_t c;
        c.op = op;
        c.key = key;
        c.value = value;
        c.drain_first = drain_first;
        cmd_q.push_back(c);
    endtask

    // weights per round: insert, lookup, delete, unused opcode
    function automatic logic [OP_W-1:0] pick_op(round_mode_t mode);
        int roll;
        int w_ins;
        int w_look;
        int w_del;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                w_ins = 85;
                w_look = 10;
                w_del = 0;
            end
            MODE_MIXED:
            begin
                w_ins = 35;
                w_look = 40;
                w_del = 20;
            end
            MODE_DRAIN:
            begin
                w_ins = 10;
                w_look = 30;
                w_del = 55;
            end
            default:
            begin
                w_ins = 25;
                w_look = 25;
                w_del = 25;
            end
        endcase
        if (roll < w_ins)
            return OP_INSERT;
        else if (roll < w_ins + w_look)
            return OP_LOOKUP;
        else if (roll < w_ins + w_look + w_del)
            return OP_DELETE;
        return OP_UNUSED;
    endfunction

    // stimulus
    initial
    begin
        int made;
        int round_len;
        round_mode_t mode;
        logic [OP_W-1:0] op;
        logic [KEY_W-1:0] key;
        bit drain;

        foreach (shadow_used[i])
            shadow_used[i] = 1'b0;

        // directed part
        add_cmd(OP_LOOKUP, '0, VAL_MAX, 1'b0);
        add_cmd(OP_DELETE, '0, '0, 1'b0);
        add_cmd(OP_UNUSED, KEY_MAX, VAL_MAX, 1'b0);
        add_cmd(OP_INSERT, '0, VAL_MAX, 1'b0);
        add_cmd(OP_INSERT, KEY_MAX, '0, 1'b0);
        add_cmd(OP_INSERT, '0, 31'd5, 1'b0);
        add_cmd(OP_LOOKUP, '0, '0, 1'b0);
        add_cmd(OP_LOOKUP, KEY_MAX, VAL_MAX, 1'b0);
        add_cmd(OP_INSERT, 31'h2AAA_AAAA, 31'h5555_5555, 1'b0);
        add_cmd(OP_INSERT, 31'h5555_5555, 31'h2AAA_AAAA, 1'b0);
        add_cmd(OP_LOOKUP, 31'h2AAA_AAAA, '0, 1'b0);
        add_cmd(OP_LOOKUP, 31'h5555_5555, '0, 1'b0);
        add_cmd(OP_LOOKUP, 31'h1234_5678, '0, 1'b0);
        add_cmd(OP_DELETE, '0, VAL_MAX, 1'b0);
        add_cmd(OP_LOOKUP, '0, '0, 1'b0);
        add_cmd(OP_INSERT, 31'd7, 31'd7, 1'b0);
        add_cmd(OP_LOOKUP, 31'd7, '0, 1'b0);
        add_cmd(OP_DELETE, '0, '0, 1'b0);
        add_cmd(OP_UNUSED, 31'h2AAA_AAAA, 31'h5555_5555, 1'b0);
        add_cmd(OP_DELETE, KEY_MAX, '0, 1'b0);
        add_cmd(OP_DELETE, 31'h2AAA_AAAA, '0, 1'b0);
        add_cmd(OP_DELETE, 31'h5555_5555, '0, 1'b0);
        add_cmd(OP_DELETE, 31'd7, '0, 1'b0);
        add_cmd(OP_LOOKUP, 31'd7, '0, 1'b0);

        foreach (key_pool[i])
            key_pool[i] = KEY_W'($urandom());

        // random rounds, the first one fills the table past full
        made = 0;
        mode = MODE_FILL;
        while (made < RANDOM_ITEMS)
        begin
            round_len = (mode == MODE_FILL) ? $urandom_range(160, 220) : $urandom_range(60, 200);
            if (round_len > RANDOM_ITEMS - made)
                round_len = RANDOM_ITEMS - made;
            repeat (4)
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = KEY_W'($urandom());
            drain = (made == 0) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < round_len; n++)
            begin
                op = pick_op(mode);
                if (mode == MODE_NOISE || $urandom_range(0, 9) == 0)
                    key = KEY_W'($urandom());
                else
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                add_cmd(op, key, VAL_W'($urandom()), drain && n == 0);
            end
            made += round_len;
            mode = round_mode_t'($urandom_range(0, 3));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (cmd_q.size() > 0 || s_tvalid || reply_q.size() > 0)
            @(posedge clk);
        repeat (SLOTS + 16) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d commands and %0d replies outstanding",
                 cmd_q.size(), reply_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                reply_q.push_back(apply_command(cur_cmd));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_q.size() > 0 && !(cmd_q[0].drain_first && reply_q.size() > 0))
                begin
                    cur_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_cmd.value, cur_cmd.key, cur_cmd.op};
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 160);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    $display("%0t: transaction with no reply pending, data %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (m_tdata[STATUS_W-1:0] !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, m_tdata[STATUS_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[STATUS_W +: VAL_W] !== want.found)
                    begin
                        $display("%0t: found_value expected %h actual %h", $time,
                                 want.found, m_tdata[STATUS_W +: VAL_W]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_W-1 -: PAD_W] !== '0)
                    begin
                        $display("%0t: pad bits expected 0 actual %h", $time,
                                 m_tdata[OUT_W-1 -: PAD_W]);
                        fail_count++;
                    end
                end
            end

            if (stall_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(64, 600);
            end
            stall_left--;
            stall_phase = (stall_phase + 1) % 11;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (stall_phase < 4);
                default: m_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

endmodule
